/* rtl/core/fol_pkg.sv */
// shared constants and codes of the frequency ordered list lookup
`timescale 1ns / 1ps
`default_nettype none
package fol_pkg;

  // default sizes
  localparam int unsigned DefDepth     = 8;
  localparam int unsigned DefKeyBits   = 32;
  localparam int unsigned DefCountBits = 16;

  // fixed widths of the port fields
  localparam int unsigned KeyInBits    = 32;
  localparam int unsigned PosOutBits   = 3;
  localparam int unsigned CountOutBits = 16;
  localparam int unsigned StatusBits   = 2;

  // mode codes
  localparam logic ModeLoad   = 1'b0;
  localparam logic ModeLocate = 1'b1;

  // status codes
  localparam logic [StatusBits-1:0] StatusDone     = 2'd0;
  localparam logic [StatusBits-1:0] StatusNotFound = 2'd1;
  localparam logic [StatusBits-1:0] StatusFull     = 2'd2;

endpackage
`default_nettype wire

/* rtl/core/fol_if.sv */
// request and result channel interfaces of the frequency ordered list lookup
`timescale 1ns / 1ps
`default_nettype none

// request channel: mode and key
interface fol_in_if import fol_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic signed [KeyInBits-1:0] key;

  modport source (output valid, mode, key, input ready);
  modport sink   (input valid, mode, key, output ready);
endinterface

// result channel: status, positions and count
interface fol_out_if import fol_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [StatusBits-1:0]   status;
  logic [PosOutBits-1:0]   old_position;
  logic [PosOutBits-1:0]   new_position;
  logic [CountOutBits-1:0] access_count;

  modport source (output valid, status, old_position, new_position, access_count,
                  input ready);
  modport sink   (input valid, status, old_position, new_position, access_count,
                  output ready);
endinterface
`default_nettype wire

/* rtl/core/fol_ram.sv */
// generic single write port ram with one registered read port
`timescale 1ns / 1ps
`default_nettype none
module fol_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8,
  localparam int unsigned AddrBits = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [AddrBits-1:0] waddr_i,
  input  wire logic [Width-1:0]    wdata_i,
  input  wire logic [AddrBits-1:0] raddr_i,
  output logic      [Width-1:0]    rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

/* rtl/core/frequency_ordered_list_lookup.sv */
// top level: key table kept in non-increasing access count order
// sequence: a load word writes its entry on acceptance; a locate word searches
//   forward up to the old position p, then shifts entries backward down to the new
//   position n and places the key there
// throughput: one word at a time; the single read and single write port of the
//   entry ram carry the forward search and the backward shift one entry a cycle
// reset: the entry count clears at once; ram contents are not cleared and are
//   never read above the entry count
`timescale 1ns / 1ps
`default_nettype none
module frequency_ordered_list_lookup import fol_pkg::*; #(
  parameter int unsigned DEPTH      = DefDepth,
  parameter int unsigned KEY_BITS   = DefKeyBits,
  parameter int unsigned COUNT_BITS = DefCountBits
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  fol_in_if.sink   in_i,
  fol_out_if.source out_o
);

  localparam int unsigned IdxBits = $clog2(DEPTH);
  localparam int unsigned EntBits = KEY_BITS + COUNT_BITS;

  // sequencer codes
  localparam logic [2:0] SIdle   = 3'd0;
  localparam logic [2:0] SSearch = 3'd1;
  localparam logic [2:0] SShift  = 3'd2;
  localparam logic [2:0] SPlace  = 3'd3;
  localparam logic [2:0] SDone   = 3'd4;

  localparam logic [IdxBits:0] FullTotal = (IdxBits + 1)'(DEPTH);

  logic [2:0]            state_q, state_d;
  logic [IdxBits:0]      total_q, total_d;
  logic [IdxBits-1:0]    idx_q, idx_d;
  logic [IdxBits-1:0]    pos_q, pos_d;
  logic [IdxBits-1:0]    dst_q, dst_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [StatusBits-1:0] status_q, status_d;

  logic                  out_valid_q, out_valid_d;
  logic [StatusBits-1:0] out_status_q;
  logic [IdxBits-1:0]    out_old_q, out_new_q;
  logic [COUNT_BITS-1:0] out_cnt_q;
  logic                  out_load;

  logic                  ram_we;
  logic [IdxBits-1:0]    ram_waddr, ram_raddr;
  logic [EntBits-1:0]    ram_wdata, ram_rdata;

  logic                         in_fire, out_fire;
  logic [KEY_BITS+KeyInBits-1:0] key_ext;
  logic [KEY_BITS-1:0]          in_key;
  logic [KEY_BITS-1:0]          rd_key;
  logic [COUNT_BITS-1:0]        rd_cnt, cnt_inc;
  logic [IdxBits-1:0]           idx_nxt, idx_prv;
  logic                         last_entry;

  // entry ram: key in the upper bits, count in the lower
  fol_ram #(
    .Width (EntBits),
    .Depth (DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // handshakes and key width fitting
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_valid_q && out_o.ready;
  assign in_i.ready = (state_q == SIdle);
  assign key_ext  = {{KEY_BITS{1'b0}}, in_i.key};
  assign in_key   = key_ext[KEY_BITS-1:0];

  // fields of the entry just read, saturating increment
  assign rd_key  = ram_rdata[EntBits-1:COUNT_BITS];
  assign rd_cnt  = ram_rdata[COUNT_BITS-1:0];
  assign cnt_inc = (rd_cnt == {COUNT_BITS{1'b1}}) ? rd_cnt : rd_cnt + 1'b1;
  assign idx_nxt = idx_q + 1'b1;
  assign idx_prv = idx_q - 1'b1;
  assign last_entry = (({1'b0, idx_q} + 1'b1) == total_q);

  // sequencer: search forward, shift backward, place
  always_comb begin
    state_d   = state_q;
    total_d   = total_q;
    idx_d     = idx_q;
    pos_d     = pos_q;
    dst_d     = dst_q;
    cnt_d     = cnt_q;
    key_d     = key_q;
    status_d  = status_q;
    ram_we    = 1'b0;
    ram_waddr = idx_nxt;
    ram_wdata = ram_rdata;
    ram_raddr = idx_q;
    out_load  = 1'b0;
    case (state_q)
      SIdle: begin
        if (in_fire) begin
          if (in_i.mode == ModeLoad) begin
            cnt_d   = '0;
            state_d = SDone;
            if (total_q == FullTotal) begin
              status_d = StatusFull;
              pos_d    = '0;
              dst_d    = '0;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = total_q[IdxBits-1:0];
              ram_wdata = {in_key, {COUNT_BITS{1'b0}}};
              total_d   = total_q + 1'b1;
              status_d  = StatusDone;
              pos_d     = total_q[IdxBits-1:0];
              dst_d     = total_q[IdxBits-1:0];
            end
          end else if (total_q == '0) begin
            status_d = StatusNotFound;
            pos_d    = '0;
            dst_d    = '0;
            cnt_d    = '0;
            state_d  = SDone;
          end else begin
            ram_raddr = '0;
            idx_d     = '0;
            key_d     = in_key;
            state_d   = SSearch;
          end
        end
      end
      SSearch: begin
        if (rd_key == key_q) begin
          pos_d = idx_q;
          cnt_d = cnt_inc;
          if (idx_q == '0) begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = {key_q, cnt_inc};
            dst_d     = '0;
            status_d  = StatusDone;
            state_d   = SDone;
          end else begin
            ram_raddr = idx_prv;
            idx_d     = idx_prv;
            state_d   = SShift;
          end
        end else if (last_entry) begin
          status_d = StatusNotFound;
          pos_d    = '0;
          dst_d    = '0;
          cnt_d    = '0;
          state_d  = SDone;
        end else begin
          ram_raddr = idx_nxt;
          idx_d     = idx_nxt;
        end
      end
      SShift: begin
        ram_we    = 1'b1;
        ram_waddr = idx_nxt;
        if (rd_cnt <= cnt_q) begin
          // pass this entry: it moves back one place
          ram_wdata = ram_rdata;
          if (idx_q == '0) begin
            dst_d   = '0;
            state_d = SPlace;
          end else begin
            ram_raddr = idx_prv;
            idx_d     = idx_prv;
          end
        end else begin
          ram_wdata = {key_q, cnt_q};
          dst_d     = idx_nxt;
          status_d  = StatusDone;
          state_d   = SDone;
        end
      end
      SPlace: begin
        ram_we    = 1'b1;
        ram_waddr = dst_q;
        ram_wdata = {key_q, cnt_q};
        status_d  = StatusDone;
        state_d   = SDone;
      end
      SDone: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // output word valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_fire) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working and result payload registers
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    pos_q    <= pos_d;
    dst_q    <= dst_d;
    cnt_q    <= cnt_d;
    key_q    <= key_d;
    status_q <= status_d;
    if (out_load) begin
      out_status_q <= status_q;
      out_old_q    <= pos_q;
      out_new_q    <= dst_q;
      out_cnt_q    <= cnt_q;
    end
  end

  // output fields at their port widths
  logic [IdxBits+PosOutBits-1:0]     old_ext, new_ext;
  logic [COUNT_BITS+CountOutBits-1:0] cnt_ext;

  assign old_ext = {{PosOutBits{1'b0}}, out_old_q};
  assign new_ext = {{PosOutBits{1'b0}}, out_new_q};
  assign cnt_ext = {{CountOutBits{1'b0}}, out_cnt_q};

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_status_q;
  assign out_o.old_position = old_ext[PosOutBits-1:0];
  assign out_o.new_position = new_ext[PosOutBits-1:0];
  assign out_o.access_count = cnt_ext[CountOutBits-1:0];

  // entry count never passes the table size
  assert property (@(posedge clk_i) disable iff (!rst_ni) total_q <= FullTotal)
    else $error("entry count above table size");

  // entry count moves only on a load into a table with room
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_fire && (in_i.mode == ModeLoad) && (total_q != FullTotal)) |=> $stable(total_q))
    else $error("entry count changed without a load");

  // backward shift stays below the matched position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SShift) |-> (idx_q < pos_q))
    else $error("shift index not below old position");

  // a full or not found result carries zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q != StatusDone)) |->
    ((out_old_q == '0) && (out_new_q == '0) && (out_cnt_q == '0)))
    else $error("failed result with nonzero fields");

endmodule
`default_nettype wire

/* tb/frequency_ordered_list_lookup_test.sv */
// self-checking test of the frequency ordered list lookup against a table predictor
`timescale 1ns / 1ps
module frequency_ordered_list_lookup_test;
  import fol_pkg::*;

  localparam int unsigned Depth       = DefDepth;
  localparam int unsigned RandomWords = 670;
  localparam int unsigned TailWords   = 60;
  // longest locate latency plus some margin
  localparam int unsigned DrainCycles = 2 * Depth + 8;
  localparam logic [DefCountBits-1:0] CountTop = '1;

  // one result word, in port field order
  typedef struct packed {
    logic [StatusBits-1:0]   status;
    logic [PosOutBits-1:0]   old_pos;
    logic [PosOutBits-1:0]   new_pos;
    logic [CountOutBits-1:0] count;
  } lookup_result_t;

  // one row of the directed sequence; fixed rows carry a typed-in answer
  typedef struct {
    logic            mode;
    logic [KeyInBits-1:0] key;
    bit              fixed;
    lookup_result_t  res;
  } script_row_t;

  localparam lookup_result_t NotFoundRes = '{StatusNotFound, 3'd0, 3'd0, 16'd0};
  localparam lookup_result_t FullRes     = '{StatusFull, 3'd0, 3'd0, 16'd0};

  logic clk_i;
  logic rst_ni;

  fol_in_if  in_ch ();
  fol_out_if out_ch ();

  frequency_ordered_list_lookup dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // directed sequence: empty table, fill with extreme keys, overflow, first lookups
  script_row_t script [20] = '{
    '{ModeLocate, 32'h0000_0000, 1'b1, NotFoundRes},
    '{ModeLoad,   32'h8000_0000, 1'b1, '{StatusDone, 3'd0, 3'd0, 16'd0}},
    '{ModeLoad,   32'h7fff_ffff, 1'b1, '{StatusDone, 3'd1, 3'd1, 16'd0}},
    '{ModeLoad,   32'h0000_0000, 1'b1, '{StatusDone, 3'd2, 3'd2, 16'd0}},
    '{ModeLoad,   32'hffff_ffff, 1'b1, '{StatusDone, 3'd3, 3'd3, 16'd0}},
    '{ModeLoad,   32'h7fff_ffff, 1'b1, '{StatusDone, 3'd4, 3'd4, 16'd0}},
    '{ModeLoad,   32'h5a5a_5a5a, 1'b1, '{StatusDone, 3'd5, 3'd5, 16'd0}},
    '{ModeLoad,   32'ha5a5_a5a5, 1'b1, '{StatusDone, 3'd6, 3'd6, 16'd0}},
    '{ModeLoad,   32'h0000_0001, 1'b1, '{StatusDone, 3'd7, 3'd7, 16'd0}},
    '{ModeLoad,   32'h1234_5678, 1'b1, FullRes},
    '{ModeLoad,   32'hffff_ffff, 1'b1, FullRes},
    '{ModeLocate, 32'h8000_0000, 1'b1, '{StatusDone, 3'd0, 3'd0, 16'd1}},
    '{ModeLocate, 32'h7fff_ffff, 1'b0, '0},
    '{ModeLocate, 32'h0000_0001, 1'b0, '0},
    '{ModeLocate, 32'hffff_ffff, 1'b0, '0},
    '{ModeLocate, 32'hdead_beef, 1'b1, NotFoundRes},
    '{ModeLocate, 32'h7fff_fffe, 1'b1, NotFoundRes},
    '{ModeLocate, 32'h0000_0001, 1'b0, '0},
    '{ModeLocate, 32'h0000_0000, 1'b0, '0},
    '{ModeLocate, 32'ha5a5_a5a5, 1'b0, '0}
  };

  // predictor copy of the key table
  logic [DefKeyBits-1:0]   tbl_key   [Depth];
  logic [DefCountBits-1:0] tbl_count [Depth];
  int unsigned             tbl_total;

  lookup_result_t pending_results [$];
  int unsigned    fail_count;
  bit             steady;
  int unsigned    burst_left;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #100_000_000;
    $display("simulation failed");
    $finish;
  end

  // table update and expected word for one accepted request
  function automatic lookup_result_t predict_lookup(input logic mode,
                                                    input logic [KeyInBits-1:0] key);
    lookup_result_t r;
    int hit_pos;
    int dst;
    logic [DefCountBits-1:0] cnt;
    r = '0;
    if (mode == ModeLoad) begin
      if (tbl_total >= Depth) begin
        r.status = StatusFull;
      end else begin
        tbl_key[tbl_total]   = key;
        tbl_count[tbl_total] = '0;
        r.status  = StatusDone;
        r.old_pos = tbl_total[PosOutBits-1:0];
        r.new_pos = tbl_total[PosOutBits-1:0];
        tbl_total++;
      end
      return r;
    end
    // forward search for the first equal key
    hit_pos = -1;
    for (int i = 0; i < int'(tbl_total); i++) begin
      if (hit_pos < 0 && tbl_key[i] == key) hit_pos = i;
    end
    if (hit_pos < 0) begin
      r.status = StatusNotFound;
      return r;
    end
    cnt = tbl_count[hit_pos];
    if (cnt != CountTop) cnt++;
    // move ahead of every earlier entry with a count not above the new one
    dst = hit_pos;
    while (dst > 0 && tbl_count[dst-1] <= cnt) dst--;
    for (int i = hit_pos; i > dst; i--) begin
      tbl_key[i]   = tbl_key[i-1];
      tbl_count[i] = tbl_count[i-1];
    end
    tbl_key[dst]   = key;
    tbl_count[dst] = cnt;
    r.status  = StatusDone;
    r.old_pos = hit_pos[PosOutBits-1:0];
    r.new_pos = dst[PosOutBits-1:0];
    r.count   = cnt;
    return r;
  endfunction

  // present one request word, with a random gap at the start of each burst
  task automatic send_word(input logic mode, input logic [KeyInBits-1:0] key,
                           input bit fixed, input lookup_result_t fixed_res);
    int unsigned gap;
    lookup_result_t predicted;
    if (!steady && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 9);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.mode  <= mode;
    in_ch.key   <= key;
    do @(posedge clk_i); while (!in_ch.ready);
    predicted = predict_lookup(mode, key);
    pending_results.push_back(fixed ? fixed_res : predicted);
    if (burst_left != 0) burst_left--;
  endtask

  // mostly hits on stored keys, tail entries favored; some misses and loads
  task automatic send_random_word();
    int unsigned pick;
    int unsigned idx;
    logic m;
    logic [KeyInBits-1:0] k;
    pick = $urandom_range(0, 99);
    if (tbl_total == 0 || pick < 8) begin
      m = ModeLocate;
      k = $urandom();
    end else if (pick < 14) begin
      // near miss: one bit off a stored key
      m = ModeLocate;
      idx = $urandom_range(0, tbl_total - 1);
      k = tbl_key[idx] ^ (32'd1 << $urandom_range(0, 31));
    end else if (pick < 22) begin
      m = ModeLoad;
      k = $urandom();
    end else begin
      m = ModeLocate;
      idx = (pick < 40) ? tbl_total - 1 : $urandom_range(0, tbl_total - 1);
      k = tbl_key[idx];
    end
    send_word(m, k, 1'b0, '0);
  endtask

  // drop valid and hold off until every expected word has come back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // compare one accepted result word with the oldest expectation
  task automatic check_result();
    lookup_result_t want;
    if (pending_results.size() == 0) begin
      $error("result word with no expectation: status %0d old %0d new %0d count %0d",
             out_ch.status, out_ch.old_position, out_ch.new_position, out_ch.access_count);
      fail_count++;
    end else begin
      want = pending_results.pop_front();
      if (out_ch.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, out_ch.status);
        fail_count++;
      end
      if (out_ch.old_position !== want.old_pos) begin
        $error("old_position: expected %0d, got %0d", want.old_pos, out_ch.old_position);
        fail_count++;
      end
      if (out_ch.new_position !== want.new_pos) begin
        $error("new_position: expected %0d, got %0d", want.new_pos, out_ch.new_position);
        fail_count++;
      end
      if (out_ch.access_count !== want.count) begin
        $error("access_count: expected %0d, got %0d", want.count, out_ch.access_count);
        fail_count++;
      end
    end
  endtask

  // result side: check accepted words, stall in segments of random style
  initial begin
    int unsigned style;
    int unsigned style_left;
    style = 0;
    style_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) check_result();
      if (style_left == 0) begin
        style = $urandom_range(0, 2);
        style_left = $urandom_range(8, 48);
      end
      style_left--;
      if (steady || style == 0) begin
        out_ch.ready <= 1'b1;
      end else if (style == 1) begin
        out_ch.ready <= ($urandom_range(0, 3) != 0);
      end else begin
        out_ch.ready <= ($urandom_range(0, 5) == 0);
      end
    end
  end

  // request side and end of run
  initial begin
    rst_ni      <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.mode  <= ModeLoad;
    in_ch.key   <= '0;
    tbl_total  = 0;
    fail_count = 0;
    steady     = 1'b0;
    burst_left = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows
    foreach (script[i]) send_word(script[i].mode, script[i].key, script[i].fixed, script[i].res);
    wait_drained();

    // random words
    repeat (RandomWords) send_random_word();
    wait_drained();

    // more random words without idling on either side
    steady = 1'b1;
    repeat (TailWords) send_random_word();
    steady = 1'b0;
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
